// ----- sv/gaussian_box_muller_sampler_core_assert.svh -----
// assertion macros for the gaussian sampler core
`ifndef GAUSSIAN_BOX_MULLER_SAMPLER_CORE_ASSERT_SVH
`define GAUSSIAN_BOX_MULLER_SAMPLER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define GBMS_ASSERT_IMPLY(label, lhs, rhs) \
label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("gbms assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define GBMS_ASSERT_NEXT(label, lhs, rhs) \
label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("gbms assertion failed");

`endif

// ----- sv/gbms_pkg.sv -----
// shared constants, types and tables for the gaussian sampler
package gbms_pkg;

    // fixed-point working format
    localparam int QB           = 28;
    localparam int UNIFORM_BITS = 32;
    localparam logic [28:0] ONE_Q       = 29'd1 << QB;
    localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;
    localparam logic [30:0] TWO_PI_Q28  = 31'd1686629713;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 8;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MEAN_VALUE    = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STD_DEVIATION = 8'd1;

    // pipeline depths of the three paths
    localparam int LOG_LAT     = 30;
    localparam int SQRT_LAT    = 34;
    localparam int TRIG_LAT    = 22;
    localparam int ANGLE_DELAY = LOG_LAT + SQRT_LAT - TRIG_LAT;

    // cosine magnitude and sign of one item
    typedef struct packed {
        logic        neg;
        logic [28:0] mag;
    } trig_out_t;

    // horner divisors of the cosine series
    function automatic logic [7:0] cos_den(input int idx);
        logic [7:0] d;
        case (idx)
            0: d = 8'd132;
            1: d = 8'd90;
            2: d = 8'd56;
            3: d = 8'd30;
            4: d = 8'd12;
            default: d = 8'd2;
        endcase
        return d;
    endfunction

    // horner divisors of the sine series
    function automatic logic [7:0] sin_den(input int idx);
        logic [7:0] d;
        case (idx)
            0: d = 8'd156;
            1: d = 8'd110;
            2: d = 8'd72;
            3: d = 8'd42;
            4: d = 8'd20;
            default: d = 8'd6;
        endcase
        return d;
    endfunction

endpackage

// ----- sv/gaussian_box_muller_sampler_core.sv -----
// top level of the box-muller gaussian sampler core
//
// in channel: in_valid / in_ready with uniform_radius and uniform_angle, one
// item per accepted pair of 32-bit uniform words.
// out channel: out_valid / out_ready with normal_sample (signed q16.16,
// saturated) and saturated_flag.
// cfg channel: cfg_valid / cfg_ready (always ready), cfg_index 0 writes
// mean_value, 1 writes std_deviation, other indexes are dropped.
// from acceptance to out_valid an item passes 30 log2 stages (normalize, 28
// squarings, subtract), 34 stages of scaling and bit-pair square root, then
// two multiply stages and the output register. the cosine path runs beside
// it in 22 stages plus a delay line.
// throughput is one item per cycle. the whole pipeline advances together;
// it holds only when its last stage is full and the output register holds
// an item that out_ready does not take, so bubbles still drain while the
// receiver stalls.
// reset clears all valid bits and sets mean 0, deviation 1.0.
`include "gaussian_box_muller_sampler_core_assert.svh"

module gaussian_box_muller_sampler_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [31:0]                           uniform_radius,
    input  logic [31:0]                           uniform_angle,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [31:0]                    normal_sample,
    output logic                                  saturated_flag,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gbms_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [31:0]                           cfg_data
);

    logic signed [31:0] mean_value_reg;
    logic [31:0]        std_deviation_reg;

    logic        en;
    logic        log_valid;
    logic [33:0] t_value;
    logic        rad_valid;
    logic [31:0] root;

    gbms_pkg::trig_out_t trig_early;
    gbms_pkg::trig_out_t trig_late;

    logic [31:0] z_reg;
    logic        f1_neg_reg;
    logic        f1_valid_reg;
    logic [63:0] prod_reg;
    logic        f2_neg_reg;
    logic        f2_valid_reg;

    logic               out_valid_reg;
    logic signed [31:0] sample_reg;
    logic               sat_reg;

    logic [60:0]        z_prod;
    logic [64:0]        rounded;
    logic [38:0]        mag_ext;
    logic signed [38:0] sum_s;
    logic signed [31:0] sample_next;
    logic               sat_next;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_value_reg    <= '0;
            std_deviation_reg <= 32'd65536;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                gbms_pkg::CFG_MEAN_VALUE:    mean_value_reg    <= cfg_data;
                gbms_pkg::CFG_STD_DEVIATION: std_deviation_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline holds only when the last stage cannot move on
    assign en       = !(f2_valid_reg && out_valid_reg && !out_ready);
    assign in_ready = en;

    // radius path
    gbms_log2_pipe u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .radius    (uniform_radius),
        .out_valid (log_valid),
        .t_value   (t_value)
    );

    gbms_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (log_valid),
        .t_value   (t_value),
        .out_valid (rad_valid),
        .root      (root)
    );

    // angle path, aligned to the radius path
    gbms_trig_pipe u_trig (
        .clk   (clk),
        .en    (en),
        .angle (uniform_angle),
        .trig  (trig_early)
    );

    gbms_delay #(
        .WIDTH ($bits(gbms_pkg::trig_out_t)),
        .DEPTH (gbms_pkg::ANGLE_DELAY)
    ) u_align (
        .clk  (clk),
        .en   (en),
        .din  (trig_early),
        .dout (trig_late)
    );

    // |z| = r * |c|
    assign z_prod = root * trig_late.mag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg      <= z_prod[59:28];
            f1_neg_reg <= trig_late.neg;
            prod_reg   <= z_reg * std_deviation_reg;
            f2_neg_reg <= f1_neg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f1_valid_reg <= rad_valid;
            f2_valid_reg <= f1_valid_reg;
        end
    end

    // round, sign, add mean, saturate
    always_comb
    begin
        rounded = {1'b0, prod_reg} + (65'd1 << 27);
        mag_ext = {2'b00, rounded[64:28]};
        sum_s   = (f2_neg_reg ? -$signed(mag_ext) : $signed(mag_ext))
                  + 39'(mean_value_reg);
        if (sum_s > 39'sd2147483647)
        begin
            sample_next = 32'sh7fffffff;
            sat_next    = 1'b1;
        end
        else if (sum_s < -39'sd2147483648)
        begin
            sample_next = 32'sh80000000;
            sat_next    = 1'b1;
        end
        else
        begin
            sample_next = sum_s[31:0];
            sat_next    = 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            out_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            sample_reg <= sample_next;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign normal_sample  = sample_reg;
    assign saturated_flag = sat_reg;

    // checks
    `GBMS_ASSERT_IMPLY(a_sat_at_rail, out_valid && saturated_flag, normal_sample == 32'sh7fffffff || normal_sample == 32'sh80000000)
    `GBMS_ASSERT_IMPLY(a_stall_cause, !in_ready, f2_valid_reg && out_valid && !out_ready)
    `GBMS_ASSERT_NEXT(a_last_stage_holds, f2_valid_reg && !en, f2_valid_reg && $stable(prod_reg))

endmodule

// ----- sv/gbms_delay.sv -----
// stallable delay line that keeps the angle path aligned with the radius path
module gbms_delay #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 42
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    // first tap
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
        end
    end

    // remaining taps
    for (genvar i = 1; i < DEPTH; i++)
    begin : g_tap
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// ----- sv/gbms_log2_pipe.sv -----
// -log2 of the radius uniform by normalization and repeated squaring
module gbms_log2_pipe (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] radius,
    output logic        out_valid,
    output logic [33:0] t_value
);

    localparam int STEPS = gbms_pkg::QB;

    logic        valid_reg [0:STEPS+1];
    logic [28:0] m_reg     [0:STEPS];
    logic [4:0]  e_reg     [0:STEPS];
    logic [27:0] frac_reg  [0:STEPS];
    logic [33:0] t_reg;

    logic [31:0] k_c;
    logic [4:0]  e_c;
    logic [60:0] m_wide;

    // zero taken as one, top bit index, mantissa in [1,2)
    always_comb
    begin
        k_c = (radius == 32'd0) ? 32'd1 : radius;
        e_c = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (k_c[i])
            begin
                e_c = 5'(i);
            end
        end
        m_wide = ({29'd0, k_c} << gbms_pkg::QB) >> e_c;
    end

    // normalize stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0]    <= m_wide[28:0];
            e_reg[0]    <= e_c;
            frac_reg[0] <= '0;
        end
    end

    // one squaring per stage, one fraction bit each
    for (genvar s = 1; s <= STEPS; s++)
    begin : g_sq
        logic [57:0] sq;
        logic [29:0] ms;
        assign sq = m_reg[s-1] * m_reg[s-1];
        assign ms = sq[57:28];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                e_reg[s] <= e_reg[s-1];
                if (ms[29])
                begin
                    m_reg[s]    <= ms[29:1];
                    frac_reg[s] <= frac_reg[s-1] | (28'd1 << (STEPS - s));
                end
                else
                begin
                    m_reg[s]    <= ms[28:0];
                    frac_reg[s] <= frac_reg[s-1];
                end
            end
        end
    end

    // integer part minus fraction
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg <= {6'(gbms_pkg::UNIFORM_BITS) - {1'b0, e_reg[STEPS]}, 28'd0}
                     - {6'd0, frac_reg[STEPS]};
        end
    end

    // valid bits
    for (genvar s = 0; s <= STEPS + 1; s++)
    begin : g_valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= (s == 0) ? in_valid : valid_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign out_valid = valid_reg[STEPS+1];
    assign t_value   = t_reg;

endmodule

// ----- sv/gbms_sqrt_pipe.sv -----
// scale by 2 ln 2 and take the square root one result bit per stage
module gbms_sqrt_pipe (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [33:0] t_value,
    output logic        out_valid,
    output logic [31:0] root
);

    localparam int ITER = 32;

    logic [45:0] plo_reg;
    logic [45:0] phi_reg;
    logic        vx_reg;
    logic        vn_reg  [0:ITER];
    logic [63:0] n_reg   [0:ITER];
    logic [63:0] res_reg [0:ITER];

    logic [63:0] sum_c;

    // two partial products of t * 2 ln 2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg <= t_value[16:0] * gbms_pkg::TWO_LN2_Q28;
            phi_reg <= t_value[33:17] * gbms_pkg::TWO_LN2_Q28;
        end
    end

    // rounded x, shifted into the radicand
    assign sum_c = ({18'd0, phi_reg} << 17) + {18'd0, plo_reg} + (64'd1 << 27);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]   <= {2'b00, sum_c[61:28], 28'd0};
            res_reg[0] <= '0;
        end
    end

    // restoring square root, one bit pair per stage
    for (genvar j = 0; j < ITER; j++)
    begin : g_iter
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] trial;
        assign trial = res_reg[j] + BIT;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (n_reg[j] >= trial)
                begin
                    n_reg[j+1]   <= n_reg[j] - trial;
                    res_reg[j+1] <= (res_reg[j] >> 1) + BIT;
                end
                else
                begin
                    n_reg[j+1]   <= n_reg[j];
                    res_reg[j+1] <= res_reg[j] >> 1;
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg <= 1'b0;
        end
        else if (en)
        begin
            vx_reg <= in_valid;
        end
    end

    for (genvar j = 0; j <= ITER; j++)
    begin : g_valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vn_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vn_reg[j] <= (j == 0) ? vx_reg : vn_reg[(j == 0) ? 0 : j-1];
            end
        end
    end

    assign out_valid = vn_reg[ITER];
    assign root      = res_reg[ITER][31:0];

endmodule

// ----- sv/gbms_trig_pipe.sv -----
// cosine of the angle uniform by octant folding and taylor series
module gbms_trig_pipe (
    input  logic                clk,
    input  logic                en,
    input  logic [31:0]         angle,
    output gbms_pkg::trig_out_t trig
);

    localparam int TERMS  = 6;
    localparam int STAGES = 3 * TERMS;

    logic [27:0] th0_reg;
    logic [1:0]  q0_reg;
    logic        sw0_reg;

    logic [27:0] theta_p [0:STAGES];
    logic [27:0] x2_p    [0:STAGES];
    logic [1:0]  quad_p  [0:STAGES];
    logic        sw_p    [0:STAGES];

    logic [28:0] cv_reg  [1:TERMS];
    logic [28:0] sv_reg  [1:TERMS];

    logic [28:0] cosr_reg;
    logic [27:0] sinr_reg;
    logic [1:0]  quad_reg;
    logic        sw_reg;
    gbms_pkg::trig_out_t out_reg;

    logic [29:0] f_c;
    logic        swap_c;
    logic [29:0] g_c;
    logic [60:0] theta_prod;
    logic [55:0] th_sq;
    logic [56:0] sin_prod;

    // fold into the first octant and scale to radians
    always_comb
    begin
        f_c        = angle[29:0];
        swap_c     = f_c > 30'h20000000;
        g_c        = swap_c ? (30'h20000000 - f_c) + 30'h20000000 : f_c;
        theta_prod = g_c * gbms_pkg::TWO_PI_Q28;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th0_reg <= theta_prod[59:32];
            q0_reg  <= angle[31:30];
            sw0_reg <= swap_c;
        end
    end

    // theta squared
    assign th_sq = th0_reg * th0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_p[0]    <= th_sq[55:28];
            theta_p[0] <= th0_reg;
            quad_p[0]  <= q0_reg;
            sw_p[0]    <= sw0_reg;
        end
    end

    // side data travels with the series stages
    for (genvar p = 1; p <= STAGES; p++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x2_p[p]    <= x2_p[p-1];
                theta_p[p] <= theta_p[p-1];
                quad_p[p]  <= quad_p[p-1];
                sw_p[p]    <= sw_p[p-1];
            end
        end
    end

    // horner steps: multiply, reciprocal, correct and subtract
    for (genvar k = 0; k < TERMS; k++)
    begin : g_term
        localparam logic [7:0]  CD = gbms_pkg::cos_den(k);
        localparam logic [7:0]  SD = gbms_pkg::sin_den(k);
        localparam logic [31:0] CM = 32'((64'd1 << 32) / CD);
        localparam logic [31:0] SM = 32'((64'd1 << 32) / SD);

        logic [28:0] cv_in;
        logic [28:0] sv_in;
        logic [56:0] cprod;
        logic [56:0] sprod;
        logic [27:0] cy_reg;
        logic [27:0] sy_reg;
        logic [27:0] cyd_reg;
        logic [27:0] syd_reg;
        logic [59:0] cqp;
        logic [59:0] sqp;
        logic [27:0] cq0_reg;
        logic [27:0] sq0_reg;
        logic [35:0] cqd;
        logic [35:0] sqd;
        logic [28:0] crem;
        logic [28:0] srem;
        logic [27:0] cq;
        logic [27:0] sq;

        if (k == 0)
        begin : g_first
            assign cv_in = gbms_pkg::ONE_Q;
            assign sv_in = gbms_pkg::ONE_Q;
        end
        else
        begin : g_next
            assign cv_in = cv_reg[k];
            assign sv_in = sv_reg[k];
        end

        assign cprod = x2_p[3*k] * cv_in;
        assign sprod = x2_p[3*k] * sv_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cy_reg <= cprod[55:28];
                sy_reg <= sprod[55:28];
            end
        end

        assign cqp = cy_reg * CM;
        assign sqp = sy_reg * SM;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cq0_reg <= cqp[59:32];
                sq0_reg <= sqp[59:32];
                cyd_reg <= cy_reg;
                syd_reg <= sy_reg;
            end
        end

        // estimate is at most one low
        always_comb
        begin
            cqd  = cq0_reg * CD;
            sqd  = sq0_reg * SD;
            crem = {1'b0, cyd_reg} - cqd[28:0];
            srem = {1'b0, syd_reg} - sqd[28:0];
            cq   = (crem >= {21'd0, CD}) ? cq0_reg + 28'd1 : cq0_reg;
            sq   = (srem >= {21'd0, SD}) ? sq0_reg + 28'd1 : sq0_reg;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cv_reg[k+1] <= gbms_pkg::ONE_Q - {1'b0, cq};
                sv_reg[k+1] <= gbms_pkg::ONE_Q - {1'b0, sq};
            end
        end
    end

    // sine is theta times its series
    assign sin_prod = theta_p[STAGES] * sv_reg[TERMS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cosr_reg <= cv_reg[TERMS];
            sinr_reg <= sin_prod[55:28];
            quad_reg <= quad_p[STAGES];
            sw_reg   <= sw_p[STAGES];
        end
    end

    // quadrant select and sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.neg <= (quad_reg == 2'd1) || (quad_reg == 2'd2);
            if (((quad_reg == 2'd0) || (quad_reg == 2'd2)) != sw_reg)
            begin
                out_reg.mag <= cosr_reg;
            end
            else
            begin
                out_reg.mag <= {1'b0, sinr_reg};
            end
        end
    end

    assign trig = out_reg;

endmodule
